// ----- hdl/trbd_pkg.sv -----
package trbd_pkg;

  localparam int unsigned NUM_ROUNDS  = 17;
  localparam int unsigned NUM_COLUMNS = 16;
  localparam int unsigned NUM_WORDS   = 4;
  localparam int unsigned ROUND_W     = $clog2(NUM_ROUNDS);
  localparam int unsigned BANK_DEPTH  = NUM_ROUNDS * 256;
  localparam int unsigned BANK_AW     = $clog2(BANK_DEPTH);

  localparam logic [ROUND_W-1:0] FIRST_ROUND   = ROUND_W'(0);
  localparam logic [ROUND_W-1:0] LAST_ROUND    = ROUND_W'(NUM_ROUNDS - 1);
  localparam logic [ROUND_W-1:0] FIRST_SHIFTED = ROUND_W'(2);
  localparam logic [ROUND_W-1:0] LAST_SHIFTED  = ROUND_W'(15);

  localparam logic [16:0] TABLE_DEPTH = 17'(NUM_ROUNDS * NUM_COLUMNS * 256);
  localparam logic [16:0] KEY_DEPTH   = 17'(NUM_ROUNDS * NUM_WORDS);

  localparam logic [1:0] OP_TABLE_WR = 2'd0;
  localparam logic [1:0] OP_KEY_WR   = 2'd1;
  localparam logic [1:0] OP_DECRYPT  = 2'd2;

  typedef logic [NUM_COLUMNS-1:0][31:0] lookups_t;
  typedef logic [NUM_WORDS-1:0][31:0]   block_t;

  // xor of the four column lookups that feed output word k
  function automatic logic [31:0] mix(input lookups_t t, input logic shifted,
                                      input logic [1:0] k);
    logic [3:0] c0;
    logic [3:0] c1;
    logic [3:0] c2;
    logic [3:0] c3;
    if (shifted) begin
      c0 = {2'b00, k};
      c1 = {2'b01, k + 2'd3};
      c2 = {2'b10, k + 2'd2};
      c3 = {2'b11, k + 2'd1};
    end else begin
      c0 = {k, 2'b00};
      c1 = {k, 2'b01};
      c2 = {k, 2'b10};
      c3 = {k, 2'b11};
    end
    return t[c0] ^ t[c1] ^ t[c2] ^ t[c3];
  endfunction

endpackage

// ----- hdl/trbd_in_if.sv -----
interface trbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [16:0] address;
  logic [31:0] load_value;
  logic [31:0] cipher_word0;
  logic [31:0] cipher_word1;
  logic [31:0] cipher_word2;
  logic [31:0] cipher_word3;

  modport source (
    output valid, opcode, address, load_value,
           cipher_word0, cipher_word1, cipher_word2, cipher_word3,
    input  ready
  );
  modport sink (
    input  valid, opcode, address, load_value,
           cipher_word0, cipher_word1, cipher_word2, cipher_word3,
    output ready
  );
endinterface

// ----- hdl/trbd_out_if.sv -----
interface trbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word0;
  logic [31:0] plain_word1;
  logic [31:0] plain_word2;
  logic [31:0] plain_word3;

  modport source (
    output valid, plain_word0, plain_word1, plain_word2, plain_word3,
    input  ready
  );
  modport sink (
    input  valid, plain_word0, plain_word1, plain_word2, plain_word3,
    output ready
  );
endinterface

// ----- hdl/table_round_block_decrypt_top.sv -----
// decrypt: one round per cycle, the last round held until the output stage frees up
// the round rate is set by the sixteen column banks, each read at most once per cycle
// in_ready is low while a decrypt runs, so a new block waits until the last one finishes
// table and key writes give no word on the output
// rst_n clears the sequencer and output valid; tables and keys keep old contents
module table_round_block_decrypt_top (
  input  logic       clk,
  input  logic       rst_n,
  trbd_in_if.sink    in_ch,
  trbd_out_if.source out_ch
);

  localparam int unsigned RW = trbd_pkg::ROUND_W;

  logic                   busy_r;
  logic [RW-1:0]          round_r;
  logic                   out_valid_r;
  trbd_pkg::block_t       out_block_r;
  trbd_pkg::block_t       key_rd_r;
  logic [31:0]            key_mem [0:trbd_pkg::NUM_ROUNDS-1][0:trbd_pkg::NUM_WORDS-1];

  trbd_pkg::lookups_t     tbl_rd;
  trbd_pkg::block_t       block_nxt;
  logic [127:0]           rd_bytes;
  logic [RW-1:0]          rd_round;
  logic                   rd_en;
  logic                   accept;
  logic                   accept_dec;
  logic                   last;
  logic                   shifted;
  logic                   finish;
  logic                   tbl_wr;
  logic                   key_wr;
  logic [trbd_pkg::NUM_COLUMNS-1:0][trbd_pkg::BANK_AW-1:0] rd_addr;

  assign accept     = in_ch.valid && in_ch.ready;
  assign accept_dec = accept && (in_ch.opcode == trbd_pkg::OP_DECRYPT);
  assign tbl_wr     = accept && (in_ch.opcode == trbd_pkg::OP_TABLE_WR)
                      && (in_ch.address < trbd_pkg::TABLE_DEPTH);
  assign key_wr     = accept && (in_ch.opcode == trbd_pkg::OP_KEY_WR)
                      && (in_ch.address < trbd_pkg::KEY_DEPTH);

  assign last    = (round_r == trbd_pkg::LAST_ROUND);
  assign shifted = (round_r >= trbd_pkg::FIRST_SHIFTED) && (round_r <= trbd_pkg::LAST_SHIFTED);
  assign finish  = busy_r && last && (!out_valid_r || out_ch.ready);

  // at the last round the lookups are held until the output stage frees up
  assign rd_en    = accept_dec || (busy_r && !last);
  assign rd_round = busy_r ? round_r + RW'(1) : trbd_pkg::FIRST_ROUND;

  always_comb begin
    for (int k = 0; k < trbd_pkg::NUM_WORDS; k++) begin
      block_nxt[k] = trbd_pkg::mix(tbl_rd, shifted, 2'(k)) ^ key_rd_r[k];
    end
    rd_bytes = busy_r ? block_nxt
                      : {in_ch.cipher_word3, in_ch.cipher_word2,
                         in_ch.cipher_word1, in_ch.cipher_word0};
    // column j always looks up byte j of the state
    for (int j = 0; j < trbd_pkg::NUM_COLUMNS; j++) begin
      rd_addr[j] = {rd_round, rd_bytes[8*j +: 8]};
    end
  end

  for (genvar j = 0; j < trbd_pkg::NUM_COLUMNS; j++) begin : g_bank
    trbd_bank u_bank (
      .clk     (clk),
      .wr_en   (tbl_wr && (in_ch.address[11:8] == 4'(j))),
      .wr_addr ({in_ch.address[16:12], in_ch.address[7:0]}),
      .wr_data (in_ch.load_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[j]),
      .rd_data (tbl_rd[j])
    );
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[in_ch.address[6:2]][in_ch.address[1:0]] <= in_ch.load_value;
    end
    if (rd_en) begin
      for (int k = 0; k < trbd_pkg::NUM_WORDS; k++) begin
        key_rd_r[k] <= key_mem[rd_round][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      round_r     <= trbd_pkg::FIRST_ROUND;
      out_valid_r <= 1'b0;
    end else begin
      if (accept_dec) begin
        busy_r  <= 1'b1;
        round_r <= trbd_pkg::FIRST_ROUND;
      end else if (finish) begin
        busy_r  <= 1'b0;
      end else if (busy_r && !last) begin
        round_r <= round_r + RW'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_block_r <= block_nxt;
    end
  end

  assign in_ch.ready        = !busy_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.plain_word0 = out_block_r[0];
  assign out_ch.plain_word1 = out_block_r[1];
  assign out_ch.plain_word2 = out_block_r[2];
  assign out_ch.plain_word3 = out_block_r[3];

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept_dec |=> busy_r && (round_r == trbd_pkg::FIRST_ROUND))
    else $error("decrypt did not start at round zero");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (round_r <= trbd_pkg::LAST_ROUND))
    else $error("round counter past last round");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r) && $past(last))
    else $error("result word without a finished decrypt");

  a_no_idle_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !accept_dec) |-> !rd_en)
    else $error("table read while idle");

endmodule

// ----- hdl/trbd_bank.sv -----
// one table column for all rounds, addressed {round, byte}
module trbd_bank (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [trbd_pkg::BANK_AW-1:0] wr_addr,
  input  logic [31:0]                 wr_data,
  input  logic                        rd_en,
  input  logic [trbd_pkg::BANK_AW-1:0] rd_addr,
  output logic [31:0]                 rd_data
);

  logic [31:0] mem [0:trbd_pkg::BANK_DEPTH-1];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- tb/table_round_block_decrypt_top_test.sv -----
module table_round_block_decrypt_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_WORDS = trbd_pkg::NUM_ROUNDS * trbd_pkg::NUM_COLUMNS * 256;
  localparam int KEY_WORDS   = trbd_pkg::NUM_ROUNDS * trbd_pkg::NUM_WORDS;

  class decrypt_scoreboard;
    bit [31:0] table_shadow [TABLE_WORDS];
    bit [31:0] key_shadow [KEY_WORDS];
    trbd_pkg::block_t plain_blocks_due [$];
    int        errors = 0;

    // 17 table rounds, rounds 2..15 pick columns on the rotated pattern
    function trbd_pkg::block_t decrypt_block(input trbd_pkg::block_t blk);
      trbd_pkg::block_t w;
      trbd_pkg::block_t nx;
      logic [3:0] col;
      logic [7:0] b;
      logic [31:0] acc;
      w = blk;
      for (int r = 0; r < trbd_pkg::NUM_ROUNDS; r++) begin
        for (int k = 0; k < trbd_pkg::NUM_WORDS; k++) begin
          acc = key_shadow[r * trbd_pkg::NUM_WORDS + k];
          for (int j = 0; j < 4; j++) begin
            if (r >= int'(trbd_pkg::FIRST_SHIFTED) && r <= int'(trbd_pkg::LAST_SHIFTED)) begin
              col = 4'(4 * j + ((k - j) & 3));
            end else begin
              col = 4'(4 * k + j);
            end
            b = w[col[3:2]][8 * col[1:0] +: 8];
            acc ^= table_shadow[r * 4096 + int'(col) * 256 + int'(b)];
          end
          nx[k] = acc;
        end
        w = nx;
      end
      return w;
    endfunction

    function void note_input(input logic [1:0] op, input logic [16:0] addr,
                             input logic [31:0] value, input trbd_pkg::block_t blk);
      case (op)
        trbd_pkg::OP_TABLE_WR: begin
          if (addr < trbd_pkg::TABLE_DEPTH) table_shadow[addr] = value;
        end
        trbd_pkg::OP_KEY_WR: begin
          if (addr < trbd_pkg::KEY_DEPTH) key_shadow[addr] = value;
        end
        trbd_pkg::OP_DECRYPT: begin
          plain_blocks_due.push_back(decrypt_block(blk));
        end
        default: ;
      endcase
    endfunction

    function void check_result(input trbd_pkg::block_t got);
      trbd_pkg::block_t want;
      if (plain_blocks_due.size() == 0) begin
        $display("%0t: unexpected plain block %h", $time, got);
        errors++;
        return;
      end
      want = plain_blocks_due.pop_front();
      for (int k = 0; k < trbd_pkg::NUM_WORDS; k++) begin
        if (got[k] !== want[k]) begin
          $display("%0t: plain_word%0d expected %h actual %h", $time, k, want[k], got[k]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return plain_blocks_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  trbd_in_if  in_ch ();
  trbd_out_if out_ch ();

  table_round_block_decrypt_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decrypt_scoreboard sb = new();

  int idle_level = 0;
  int burst_left = 0;
  int rx_cycle   = 0;
  int stall_left = 0;

  // state byte p entering round r is always zero or gen_byte[r][p]
  // so only two table entries per column and round are ever looked up
  bit [7:0] gen_byte [trbd_pkg::NUM_ROUNDS + 1][trbd_pkg::NUM_COLUMNS];

  always #6 clk = ~clk;

  // receiver: free flow, random drops, long stalls, alternating ready
  always @(posedge clk) begin
    logic ready_next;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.plain_word3, out_ch.plain_word2,
                       out_ch.plain_word1, out_ch.plain_word0});
    end
    case ((rx_cycle / 400) % 4)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 3) != 0);
      2: begin
        if (stall_left > 0) begin
          stall_left--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
        end
      end
      default: ready_next = rx_cycle[0];
    endcase
    rx_cycle++;
    out_ch.ready <= ready_next;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic trbd_pkg::block_t rand_block();
    trbd_pkg::block_t blk;
    for (int k = 0; k < trbd_pkg::NUM_WORDS; k++) blk[k] = rand_word();
    return blk;
  endfunction

  // output word of round r that column c feeds
  function automatic int feed_word(input int r, input int c);
    if (r >= int'(trbd_pkg::FIRST_SHIFTED) && r <= int'(trbd_pkg::LAST_SHIFTED)) begin
      return ((c & 3) + (c >> 2)) & 3;
    end
    return c >> 2;
  endfunction

  // word k of the state at stage s, one bit of raw picks each byte
  function automatic logic [31:0] legal_word(input int s, input int k, input logic [31:0] raw);
    logic [31:0] w;
    for (int i = 0; i < 4; i++) begin
      w[8 * i +: 8] = raw[8 * i] ? gen_byte[s][4 * k + i] : 8'h00;
    end
    return w;
  endfunction

  function automatic logic [31:0] table_value(input logic [16:0] addr, input logic [31:0] raw);
    int r;
    int c;
    int b;
    if (addr >= trbd_pkg::TABLE_DEPTH) return raw;
    r = int'(addr[16:12]);
    c = int'(addr[11:8]);
    b = int'(addr[7:0]);
    // entries that are never looked up can hold anything
    if (b != 0 && b != int'(gen_byte[r][c])) return raw;
    return legal_word(r + 1, feed_word(r, c), raw);
  endfunction

  function automatic logic [31:0] key_value(input int a, input logic [31:0] raw);
    return legal_word(a / 4 + 1, a % 4, raw);
  endfunction

  function automatic trbd_pkg::block_t legal_block(input trbd_pkg::block_t raw);
    trbd_pkg::block_t blk;
    for (int k = 0; k < trbd_pkg::NUM_WORDS; k++) blk[k] = legal_word(0, k, raw[k]);
    return blk;
  endfunction

  // hold the word until taken, then either keep the burst going or pause
  task automatic push_item(input logic [1:0] op, input logic [16:0] addr,
                           input logic [31:0] value, input trbd_pkg::block_t blk);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.address      <= addr;
    in_ch.load_value   <= value;
    in_ch.cipher_word0 <= blk[0];
    in_ch.cipher_word1 <= blk[1];
    in_ch.cipher_word2 <= blk[2];
    in_ch.cipher_word3 <= blk[3];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, addr, value, blk);
    if (idle_level != 0 && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, idle_level);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic decrypt(input trbd_pkg::block_t blk);
    push_item(trbd_pkg::OP_DECRYPT, 17'($urandom), $urandom, blk);
  endtask

  initial begin
    int          pick;
    int          r_pick;
    int          c_pick;
    int          a_pick;
    logic [16:0] addr;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = trbd_pkg::OP_TABLE_WR;
    in_ch.address      = '0;
    in_ch.load_value   = '0;
    in_ch.cipher_word0 = '0;
    in_ch.cipher_word1 = '0;
    in_ch.cipher_word2 = '0;
    in_ch.cipher_word3 = '0;
    out_ch.ready       = 1'b0;
    for (int r = 0; r <= trbd_pkg::NUM_ROUNDS; r++) begin
      for (int p = 0; p < trbd_pkg::NUM_COLUMNS; p++) begin
        gen_byte[r][p] = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(1, 254));
      end
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every table entry and key word that a decrypt can reach is loaded first
    idle_level = 2;
    for (int r = 0; r < trbd_pkg::NUM_ROUNDS; r++) begin
      for (int c = 0; c < trbd_pkg::NUM_COLUMNS; c++) begin
        addr = 17'(r * 4096 + c * 256);
        push_item(trbd_pkg::OP_TABLE_WR, addr, table_value(addr, $urandom), rand_block());
        addr = 17'(r * 4096 + c * 256 + int'(gen_byte[r][c]));
        push_item(trbd_pkg::OP_TABLE_WR, addr, table_value(addr, $urandom), rand_block());
      end
    end
    for (int k = 0; k < KEY_WORDS; k++) begin
      push_item(trbd_pkg::OP_KEY_WR, 17'(k), key_value(k, $urandom), rand_block());
    end

    idle_level = 0;
    decrypt('0);
    decrypt(legal_block('1));
    decrypt(legal_block({32'h0123_4567, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000}));
    push_item(trbd_pkg::OP_TABLE_WR, 17'd0, table_value(17'd0, 32'hFFFF_FFFF), rand_block());
    push_item(trbd_pkg::OP_TABLE_WR, 17'(TABLE_WORDS - 1),
              table_value(17'(TABLE_WORDS - 1), 32'h0000_0000), rand_block());
    push_item(trbd_pkg::OP_KEY_WR, 17'd0, key_value(0, 32'h0000_0000), rand_block());
    push_item(trbd_pkg::OP_KEY_WR, 17'(KEY_WORDS - 1), key_value(KEY_WORDS - 1, 32'hFFFF_FFFF),
              rand_block());
    decrypt('0);
    decrypt(legal_block('1));
    // writes past the end of either store must leave both untouched
    push_item(trbd_pkg::OP_TABLE_WR, trbd_pkg::TABLE_DEPTH, $urandom, rand_block());
    push_item(trbd_pkg::OP_TABLE_WR, 17'h1_8000, $urandom, rand_block());
    push_item(trbd_pkg::OP_TABLE_WR, 17'h1_FFFF, $urandom, rand_block());
    push_item(trbd_pkg::OP_KEY_WR, trbd_pkg::KEY_DEPTH, $urandom, rand_block());
    push_item(trbd_pkg::OP_KEY_WR, 17'd127, $urandom, rand_block());
    push_item(trbd_pkg::OP_KEY_WR, 17'h1_FFFF, $urandom, rand_block());
    push_item(OP_UNUSED, 17'd0, $urandom, rand_block());
    push_item(OP_UNUSED, 17'h1_FFFF, 32'hFFFF_FFFF, '1);
    decrypt('0);
    decrypt(legal_block('1));
    decrypt(legal_block(rand_block()));
    decrypt(legal_block(rand_block()));

    for (int n = 0; n < 470; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_level = 0;
          1: idle_level = 2;
          2: idle_level = 6;
          default: idle_level = 20;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        decrypt(legal_block(rand_block()));
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) != 0) begin
          r_pick = $urandom_range(0, trbd_pkg::NUM_ROUNDS - 1);
          c_pick = $urandom_range(0, trbd_pkg::NUM_COLUMNS - 1);
          addr = 17'(r_pick * 4096 + c_pick * 256
                     + (($urandom_range(0, 1) != 0) ? int'(gen_byte[r_pick][c_pick]) : 0));
        end else begin
          addr = 17'($urandom_range(0, TABLE_WORDS - 1));
        end
        push_item(trbd_pkg::OP_TABLE_WR, addr, table_value(addr, rand_word()), rand_block());
      end else if (pick < 85) begin
        a_pick = $urandom_range(0, KEY_WORDS - 1);
        push_item(trbd_pkg::OP_KEY_WR, 17'(a_pick), key_value(a_pick, rand_word()),
                  rand_block());
      end else if (pick < 90) begin
        push_item(trbd_pkg::OP_TABLE_WR, 17'($urandom_range(TABLE_WORDS, 17'h1_FFFF)),
                  $urandom, rand_block());
      end else if (pick < 95) begin
        push_item(trbd_pkg::OP_KEY_WR, 17'($urandom_range(KEY_WORDS, 17'h1_FFFF)), $urandom,
                  rand_block());
      end else begin
        push_item(OP_UNUSED, 17'($urandom), $urandom, rand_block());
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d plain blocks never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("table_round_block_decrypt_top verification clean");
    end else begin
      $display("table_round_block_decrypt_top verification failed");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("table_round_block_decrypt_top verification failed");
    $finish;
  end

endmodule
